### rtl/interval_set_tracker_macros.svh
// Assertion helpers for the interval set tracker.
`ifndef INTERVAL_SET_TRACKER_MACROS_SVH
`define INTERVAL_SET_TRACKER_MACROS_SVH

// Implication checked every clock edge, skipped while in reset.
`define IST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication.
`define IST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/ist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ist_pkg;
  localparam int DEPTH = 64;
  localparam int COORD_BITS = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [31:0] range_start;
    logic [31:0] range_end;
  } in_word_t;

  typedef struct packed {
    logic covered;
    logic overflow;
  } out_word_t;

  // one interval travelling along the chain
  typedef struct packed {
    logic   vld;
    coord_t lo;
    coord_t hi;
  } ival_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic   load;    // snapshot table into shadow
    logic   step;    // one shift of the rebuild chain
    logic   pop;     // rotate the shadow ring one slot toward the tail
    logic   commit;  // copy rebuilt table back
    logic   restore; // put the shadow back (rejected item)
    logic   rem;     // remove mode
    coord_t s;
    coord_t e;
  } cell_ctl_t;
endpackage
`default_nettype wire

### rtl/ist_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One table slot. Holds an interval and a shadow copy; during a rebuild the
// table shifts one slot toward the tail on each step, fed at the chain head,
// and the shadows rotate as a ring so the tail shadow gives the old entries.
module ist_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ist_pkg::cell_ctl_t ctl,
  input  wire ist_pkg::ival_t     prev,
  output      ist_pkg::ival_t     cur,
  input  wire ist_pkg::ival_t     sh_prev,
  output      ist_pkg::ival_t     sh_cur,
  output      logic               cov
);
  import ist_pkg::*;

  ival_t q_r, q_nxt, sh_r, sh_nxt;

  assign cur    = q_r;
  assign sh_cur = sh_r;
  assign cov    = q_r.vld && (q_r.lo <= ctl.s) && (q_r.hi >= ctl.e);

  always_comb begin
    q_nxt  = q_r;
    sh_nxt = sh_r;
    if (ctl.load) begin
      sh_nxt = q_r;
    end else if (ctl.pop) begin
      sh_nxt = sh_prev;
    end
    if (ctl.step) begin
      q_nxt = prev;
    end else if (ctl.restore) begin
      q_nxt = sh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld  <= 1'b0;
      sh_r.vld <= 1'b0;
    end else begin
      q_r.vld  <= q_nxt.vld;
      sh_r.vld <= sh_nxt.vld;
    end
    q_r.lo  <= q_nxt.lo;
    q_r.hi  <= q_nxt.hi;
    sh_r.lo <= sh_nxt.lo;
    sh_r.hi <= sh_nxt.hi;
  end
endmodule
`default_nettype wire

### rtl/ist_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// Rebuild sequencer. The shadow table is streamed in order, one entry per
// cycle while no spill is held, and the rebuilt list is pushed into the
// chain head, at most one interval per cycle. Old entries come from the tail
// shadow; the ring turns once per pop, DEPTH pops bring it back into place.
module ist_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ist_pkg::in_word_t  in_word,
  input  wire logic               in_valid,
  output      logic               in_stall,
  output      ist_pkg::out_word_t out_word,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      ist_pkg::cell_ctl_t ctl,
  output      ist_pkg::ival_t     head,
  input  wire ist_pkg::ival_t     old_ival,
  input  wire logic               any_cov
);
  import ist_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_TAIL = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]       st_r, st_nxt;
  logic [1:0]       mode_r;
  coord_t           s_r, e_r, ms_r, ms_nxt, me_r, me_nxt;
  logic             placed_r, placed_nxt;
  logic [CNT_W:0]   k_r, k_nxt;
  logic [CNT_W:0]   left_r, left_nxt;
  logic             cov_r, ovf_r, ovf_nxt;
  logic             ovf_o_r;
  logic             pend_r;
  logic [1:0]       npush;
  ival_t            p0;
  ival_t            spill_r, spill_nxt;
  coord_t           in_s, in_e;

  assign in_s = in_word.range_start[COORD_BITS-1:0];
  assign in_e = in_word.range_end[COORD_BITS-1:0];

  assign in_stall  = (st_r != ST_IDLE) || pend_r;
  assign out_valid = pend_r;
  assign out_word  = '{covered: cov_r, overflow: ovf_o_r};

  // per-cycle item produced from one old entry (or a held spill)
  always_comb begin
    st_nxt     = st_r;
    ms_nxt     = ms_r;
    me_nxt     = me_r;
    placed_nxt = placed_r;
    k_nxt      = k_r;
    left_nxt   = left_r;
    spill_nxt  = spill_r;
    ovf_nxt    = ovf_r;
    p0         = '0;
    npush      = 2'd0;
    ctl        = '0;
    ctl.s      = s_r;
    ctl.e      = e_r;
    ctl.rem    = (mode_r == MODE_REMOVE);
    head       = '0;
    case (st_r)
      ST_LOAD: begin
        ctl.load = 1'b1;
        st_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        if (spill_r.vld) begin
          p0 = spill_r;
          npush = 2'd1;
          spill_nxt = '0;
        end else if (left_r != '0) begin
          ctl.pop  = 1'b1;
          left_nxt = left_r - 1'b1;
          // empty slots only turn the ring
          if (old_ival.vld) begin
            if (mode_r == MODE_REMOVE) begin
              if (old_ival.hi <= s_r || old_ival.lo >= e_r) begin
                p0 = old_ival; npush = 2'd1;
              end else begin
                if (old_ival.lo < s_r) begin
                  p0 = '{vld: 1'b1, lo: old_ival.lo, hi: s_r}; npush = 2'd1;
                  if (old_ival.hi > e_r)
                    spill_nxt = '{vld: 1'b1, lo: e_r, hi: old_ival.hi};
                end else if (old_ival.hi > e_r) begin
                  p0 = '{vld: 1'b1, lo: e_r, hi: old_ival.hi}; npush = 2'd1;
                end
              end
            end else begin
              if (old_ival.hi < s_r) begin
                p0 = old_ival; npush = 2'd1;
              end else if (old_ival.lo > e_r) begin
                if (!placed_r) begin
                  p0 = '{vld: 1'b1, lo: ms_r, hi: me_r};
                  spill_nxt = old_ival;
                  placed_nxt = 1'b1;
                end else begin
                  p0 = old_ival;
                end
                npush = 2'd1;
              end else begin
                if (old_ival.lo < ms_r) ms_nxt = old_ival.lo;
                if (old_ival.hi > me_r) me_nxt = old_ival.hi;
              end
            end
          end
        end else begin
          st_nxt = ST_TAIL;
        end
        if (npush != 2'd0) begin
          ctl.step = 1'b1;
          head     = p0;
          k_nxt    = k_r + 1'b1;
          if (k_r >= (CNT_W+1)'(DEPTH)) ovf_nxt = 1'b1;
        end
      end
      ST_TAIL: begin
        if (mode_r == MODE_ADD && !placed_r) begin
          ctl.step   = 1'b1;
          head       = '{vld: 1'b1, lo: ms_r, hi: me_r};
          placed_nxt = 1'b1;
          k_nxt      = k_r + 1'b1;
          if (k_r >= (CNT_W+1)'(DEPTH)) ovf_nxt = 1'b1;
        end else begin
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // pushes walked toward the tail; pad shifts align entry 0 to the tail
        if (left_r != '0) begin
          ctl.step = 1'b1;
          left_nxt = left_r - 1'b1;
        end else begin
          if (ovf_r) ctl.restore = 1'b1;
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      pend_r <= 1'b0;
    end else begin
      if (pend_r && !out_stall) pend_r <= 1'b0;
      if (st_r == ST_IDLE && in_valid && !in_stall) begin
        if (in_s < in_e && (in_word.mode == MODE_ADD || in_word.mode == MODE_REMOVE)) begin
          st_r <= ST_LOAD;
        end else begin
          pend_r  <= 1'b1;
          ovf_o_r <= 1'b0;
          cov_r   <= (in_s < in_e && in_word.mode == MODE_QUERY) ? any_cov : 1'b0;
        end
      end else if (st_r == ST_OUT) begin
        st_r    <= ST_IDLE;
        pend_r  <= 1'b1;
        cov_r   <= 1'b0;
        ovf_o_r <= ovf_r;
      end else begin
        st_r <= st_nxt;
      end
    end
    if (st_r == ST_IDLE) begin
      mode_r   <= in_word.mode;
      s_r      <= in_s;
      e_r      <= in_e;
      ms_r     <= in_s;
      me_r     <= in_e;
      placed_r <= 1'b0;
      k_r      <= '0;
      ovf_r    <= 1'b0;
      spill_r  <= '0;
      left_r   <= (CNT_W+1)'(DEPTH);
    end else if (st_r == ST_TAIL && st_nxt == ST_FIN) begin
      // walk the fresh list to the top of the chain: DEPTH - k more shifts
      left_r <= ((CNT_W+1)'(DEPTH) > k_r) ? (CNT_W+1)'(DEPTH) - k_r : '0;
    end else begin
      ms_r     <= ms_nxt;
      me_r     <= me_nxt;
      placed_r <= placed_nxt;
      k_r      <= k_nxt;
      left_r   <= left_nxt;
      spill_r  <= spill_nxt;
      ovf_r    <= ovf_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/interval_set_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// Interval set tracker: a table of up to DEPTH disjoint half-open intervals.
// Input channel (in_valid/in_stall/in_word) takes a mode and a range:
// add merges the range into the set, remove cuts it out, query asks
// whether one stored interval holds the whole range.
// Output channel (out_valid/out_stall/out_word) gives one word per item:
// covered for a query, overflow for a rejected add or remove.
// Queries and no-op items have their result valid the cycle after
// acceptance; the cells compare the range in parallel.
// Add and remove rebuild the table through the cell chain: the old table
// streams out of the rotating shadow ring, pausing for each split or merge
// spill, while the new list shifts in at the chain head; then pad
// shifts align it. The result follows the LOAD, SCAN, TAIL, FIN and OUT
// states, whose length is set by the chain length and the words pushed.
// An update that would need more than DEPTH entries restores the shadow.
// One item is in flight at a time; in_stall is high while it works and
// while its result waits, so the next word can be taken in the cycle
// after the result is taken. A stalled result holds until taken.
// Reset empties the table at once.
module interval_set_tracker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire ist_pkg::in_word_t  in_word,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      ist_pkg::out_word_t out_word
);
  import ist_pkg::*;

  cell_ctl_t  ctl;
  ival_t      head;
  ival_t      chain [DEPTH+1];
  ival_t      sh_chain [DEPTH];
  logic [DEPTH-1:0] cov;
  ival_t      old_ival;
  cell_ctl_t  cell_ctl;

  // during a query, compare against the incoming range
  always_comb begin
    cell_ctl = ctl;
    if (!in_stall) begin
      cell_ctl.s = in_word.range_start[COORD_BITS-1:0];
      cell_ctl.e = in_word.range_end[COORD_BITS-1:0];
    end
  end

  assign chain[0] = head;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ist_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (cell_ctl),
      .prev   (chain[g]),
      .cur    (chain[g+1]),
      .sh_prev(sh_chain[(g + DEPTH - 1) % DEPTH]),
      .sh_cur (sh_chain[g]),
      .cov    (cov[g])
    );
  end

  // old entries in table order: the tail shadow, the ring turns per pop
  assign old_ival = sh_chain[DEPTH-1];

  ist_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_word (out_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ctl      (ctl),
    .head     (head),
    .old_ival (old_ival),
    .any_cov  (|cov)
  );
endmodule
`default_nettype wire

### rtl/ist_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ist_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire ist_pkg::in_word_t  in_word,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire ist_pkg::out_word_t out_word
);
  import ist_pkg::*;
`include "interval_set_tracker_macros.svh"

  `IST_ASSERT_IMP(a_one_flag, clk, rst_n, out_valid, !(out_word.covered && out_word.overflow))
  `IST_ASSERT_IMP(a_busy_on_result, clk, rst_n, out_valid, in_stall)
  `IST_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))
  `IST_ASSERT_NEXT(a_accept_blocks, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind interval_set_tracker ist_checker u_ist_checker (.*);
`default_nettype wire
